// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/gsa_pkg.sv =====
`default_nettype none
package gsa_pkg;

    // Table geometry.
    localparam int MAX_SLOTS = 1024;
    localparam int ID_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W     = ID_W + 1;
    localparam int GEN_W     = 16;
    localparam int REQ_W     = 3;
    localparam int ST_W      = 2;
    localparam int COND_W    = 2;

    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(MAX_SLOTS);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COMMIT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_NEXT    = 3'd4;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

    // Slot conditions.
    localparam logic [COND_W-1:0] COND_UNUSED = 2'd0;
    localparam logic [COND_W-1:0] COND_LIVE   = 2'd1;
    localparam logic [COND_W-1:0] COND_MARKED = 2'd2;
    localparam logic [COND_W-1:0] COND_FREED  = 2'd3;

    // One slot table entry.
    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [GEN_W-1:0]  gen;
    } t_slot;

    // Slot table write port.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        t_slot           data;
    } t_slot_wr;

    // Slot table read port.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
    } t_slot_rd;

endpackage
`default_nettype wire

// ===== hw/rtl/gsa_slot_ram.sv =====
`default_nettype none
module gsa_slot_ram (
    input  wire              i_clk,
    input  gsa_pkg::t_slot_wr i_wr,
    input  gsa_pkg::t_slot_rd i_rd,
    output gsa_pkg::t_slot   o_rd_data
);
    import gsa_pkg::*;

    // Generation and condition of every slot. Entries above the fill count
    // are never read before they are written, so no clearing is needed.
    t_slot r_mem [MAX_SLOTS];
    t_slot r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== hw/rtl/generational_slot_allocator_core.sv =====
// Generational slot allocator: hands out handles made of a slot id and a
// generation, and checks, destroys, commits and walks them.
// Request channel: i_valid / o_ready with i_req_type, i_key_id, i_key_gen,
// i_key_is_null and i_from_start. Result channel: o_valid / i_ready with
// o_status, o_slot_id, o_slot_gen and o_freed_count, one result per request.
// One request is worked at a time; o_ready is high only while idle.
// Steps from transfer to result: allocate of a fresh slot writes the table
// and finishes; allocate from the free stack reads the stack, then the table;
// lookup and destroy read the table; rejected requests go straight to the result.
// Commit and next-live walk the table through one read port, one slot a
// cycle, from the start index up to slots_in_use.
// A finished result sits in an output register; a stalled receiver holds the
// block in its final step until the register frees, then the block idles.
// Reset (synchronous, active low) empties the free stack and the fill count;
// table entries above the fill count are written before they are read, so
// no clearing pass is needed and the block is ready straight after reset.
`default_nettype none
module generational_slot_allocator_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [gsa_pkg::REQ_W-1:0] i_req_type,
    input  wire [gsa_pkg::ID_W-1:0]  i_key_id,
    input  wire [gsa_pkg::GEN_W-1:0] i_key_gen,
    input  wire                     i_key_is_null,
    input  wire                     i_from_start,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [gsa_pkg::ST_W-1:0]  o_status,
    output logic [gsa_pkg::ID_W-1:0]  o_slot_id,
    output logic [gsa_pkg::GEN_W-1:0] o_slot_gen,
    output logic [gsa_pkg::CNT_W-1:0] o_freed_count
);
    import gsa_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_ALC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Control state.
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_fsl, n_fsl;
    logic [CNT_W-1:0] r_siu, n_siu;
    logic             r_pv, n_pv;
    logic             r_ovalid, n_ovalid;

    // Working payload.
    logic [REQ_W-1:0] r_op, n_op;
    logic [ID_W-1:0]  r_kid, n_kid;
    logic [GEN_W-1:0] r_kgen, n_kgen;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_lim, n_lim;
    logic [ID_W-1:0]  r_pidx, n_pidx;
    logic [CNT_W-1:0] r_freed, n_freed;
    logic [ST_W-1:0]  r_res_st, n_res_st;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic [GEN_W-1:0] r_res_gen, n_res_gen;
    logic [CNT_W-1:0] r_res_freed, n_res_freed;
    logic [ST_W-1:0]  r_o_st, n_o_st;
    logic [ID_W-1:0]  r_o_id, n_o_id;
    logic [GEN_W-1:0] r_o_gen, n_o_gen;
    logic [CNT_W-1:0] r_o_freed, n_o_freed;

    // Slot table ports.
    t_slot_wr slot_wr;
    t_slot_rd slot_rd;
    t_slot    slot_q;

    // Free stack ports.
    logic            stk_we;
    logic [ID_W-1:0] stk_waddr;
    logic [ID_W-1:0] stk_wdata;
    logic            stk_re;
    logic [ID_W-1:0] stk_raddr;
    logic [ID_W-1:0] r_stk_q;
    logic [ID_W-1:0] r_stk_mem [MAX_SLOTS];

    logic             out_free;
    logic             hit;
    logic [CNT_W-1:0] next_start;

    gsa_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd      (slot_rd),
        .o_rd_data (slot_q)
    );

    // Free stack memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_raddr];
        end
    end

    assign out_free   = !r_ovalid || i_ready;
    assign next_start = CNT_W'(i_key_id) + 1'b1;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_fsl       = r_fsl;
        n_siu       = r_siu;
        n_pv        = r_pv;
        n_ovalid    = r_ovalid;
        n_op        = r_op;
        n_kid       = r_kid;
        n_kgen      = r_kgen;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_pidx      = r_pidx;
        n_freed     = r_freed;
        n_res_st    = r_res_st;
        n_res_id    = r_res_id;
        n_res_gen   = r_res_gen;
        n_res_freed = r_res_freed;
        n_o_st      = r_o_st;
        n_o_id      = r_o_id;
        n_o_gen     = r_o_gen;
        n_o_freed   = r_o_freed;
        slot_wr     = '0;
        slot_rd     = '0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_raddr   = '0;
        hit         = 1'b0;

        // The receiver takes the result.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op        = i_req_type;
                    n_kid       = i_key_id;
                    n_kgen      = i_key_gen;
                    n_res_st    = ST_INVALID;
                    n_res_id    = '0;
                    n_res_gen   = '0;
                    n_res_freed = '0;
                    n_state     = S_DONE;
                    case (i_req_type)
                        REQ_ALLOC: begin
                            if (r_fsl != '0) begin
                                // Pop the top of the free stack.
                                stk_re    = 1'b1;
                                stk_raddr = ID_W'(r_fsl - 1'b1);
                                n_fsl     = r_fsl - 1'b1;
                                n_state   = S_POP;
                            end else if (r_siu != SLOT_LIMIT) begin
                                // Take the next never-used slot.
                                slot_wr.en        = 1'b1;
                                slot_wr.addr      = r_siu[ID_W-1:0];
                                slot_wr.data.cond = COND_LIVE;
                                slot_wr.data.gen  = '0;
                                n_siu             = r_siu + 1'b1;
                                n_res_st          = ST_OK;
                                n_res_id          = r_siu[ID_W-1:0];
                            end else begin
                                n_res_st = ST_FULL;
                            end
                        end
                        REQ_LOOKUP, REQ_DESTROY: begin
                            if (i_req_type == REQ_DESTROY) begin
                                n_res_id = i_key_id;
                            end
                            if (!i_key_is_null && CNT_W'(i_key_id) < r_siu) begin
                                slot_rd.en   = 1'b1;
                                slot_rd.addr = i_key_id;
                                n_state      = S_CHK;
                            end
                        end
                        REQ_COMMIT: begin
                            n_idx   = '0;
                            n_lim   = r_siu;
                            n_pv    = 1'b0;
                            n_freed = '0;
                            n_state = S_WALK;
                        end
                        REQ_NEXT: begin
                            if (i_from_start || !i_key_is_null) begin
                                n_idx   = i_from_start ? '0 : next_start;
                                n_lim   = r_siu;
                                n_pv    = 1'b0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_res_st = ST_INVALID;
                        end
                    endcase
                end
            end

            S_POP: begin
                // Popped id is ready; fetch its generation.
                slot_rd.en   = 1'b1;
                slot_rd.addr = r_stk_q;
                n_kid        = r_stk_q;
                n_state      = S_ALC;
            end

            S_ALC: begin
                slot_wr.en        = 1'b1;
                slot_wr.addr      = r_kid;
                slot_wr.data.cond = COND_LIVE;
                slot_wr.data.gen  = slot_q.gen;
                n_res_st          = ST_OK;
                n_res_id          = r_kid;
                n_res_gen         = slot_q.gen;
                n_state           = S_DONE;
            end

            S_CHK: begin
                if (r_op == REQ_LOOKUP) begin
                    if (slot_q.gen == r_kgen) begin
                        n_res_st  = ST_OK;
                        n_res_id  = r_kid;
                        n_res_gen = slot_q.gen;
                    end
                end else if (slot_q.cond == COND_LIVE || slot_q.cond == COND_MARKED) begin
                    slot_wr.en        = 1'b1;
                    slot_wr.addr      = r_kid;
                    slot_wr.data.cond = COND_MARKED;
                    slot_wr.data.gen  = slot_q.gen;
                    n_res_st          = ST_OK;
                    n_res_gen         = slot_q.gen;
                end
                n_state = S_DONE;
            end

            S_WALK: begin
                // Evaluate the slot read in the previous cycle.
                if (r_pv) begin
                    if (r_op == REQ_COMMIT) begin
                        if (slot_q.cond == COND_MARKED && r_fsl != SLOT_LIMIT) begin
                            slot_wr.en        = 1'b1;
                            slot_wr.addr      = r_pidx;
                            slot_wr.data.cond = COND_FREED;
                            slot_wr.data.gen  = slot_q.gen + 1'b1;
                            stk_we            = 1'b1;
                            stk_waddr         = r_fsl[ID_W-1:0];
                            stk_wdata         = r_pidx;
                            n_fsl             = r_fsl + 1'b1;
                            n_freed           = r_freed + 1'b1;
                        end
                    end else if (slot_q.cond == COND_LIVE) begin
                        hit       = 1'b1;
                        n_res_st  = ST_OK;
                        n_res_id  = r_pidx;
                        n_res_gen = slot_q.gen;
                        n_pv      = 1'b0;
                        n_state   = S_DONE;
                    end
                end
                // Issue the next read, or close the walk once drained.
                if (!hit) begin
                    if (r_idx < r_lim) begin
                        slot_rd.en   = 1'b1;
                        slot_rd.addr = r_idx[ID_W-1:0];
                        n_pv         = 1'b1;
                        n_pidx       = r_idx[ID_W-1:0];
                        n_idx        = r_idx + 1'b1;
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            if (r_op == REQ_COMMIT) begin
                                n_res_st    = ST_OK;
                                n_res_freed = r_freed;
                            end
                            n_state = S_DONE;
                        end
                    end
                end
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_o_st    = r_res_st;
                    n_o_id    = r_res_id;
                    n_o_gen   = r_res_gen;
                    n_o_freed = r_res_freed;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fsl    <= '0;
            r_siu    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fsl    <= n_fsl;
            r_siu    <= n_siu;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_kid       <= n_kid;
        r_kgen      <= n_kgen;
        r_idx       <= n_idx;
        r_lim       <= n_lim;
        r_pidx      <= n_pidx;
        r_freed     <= n_freed;
        r_res_st    <= n_res_st;
        r_res_id    <= n_res_id;
        r_res_gen   <= n_res_gen;
        r_res_freed <= n_res_freed;
        r_o_st      <= n_o_st;
        r_o_id      <= n_o_id;
        r_o_gen     <= n_o_gen;
        r_o_freed   <= n_o_freed;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_o_st;
    assign o_slot_id     = r_o_id;
    assign o_slot_gen    = r_o_gen;
    assign o_freed_count = r_o_freed;

endmodule
`default_nettype wire

// ===== hw/rtl/gsa_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module gsa_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_valid,
    input wire                      o_ready,
    input wire                      o_valid,
    input wire                      i_ready,
    input wire [gsa_pkg::ST_W-1:0]  o_status,
    input wire [gsa_pkg::ID_W-1:0]  o_slot_id,
    input wire [gsa_pkg::GEN_W-1:0] o_slot_gen,
    input wire [gsa_pkg::CNT_W-1:0] o_freed_count
);
    import gsa_pkg::*;

    // One request at a time: a transfer in leaves the block busy.
    `GSA_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // A stalled result holds.
    `GSA_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_slot_id) && $stable(o_slot_gen))

    // A full table returns nothing but the status.
    `GSA_ASSERT_IMP(a_full_clean, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_slot_id == '0 && o_slot_gen == '0 && o_freed_count == '0)

    // Only a successful commit reports freed slots.
    `GSA_ASSERT_IMP(a_freed_ok, i_clk, i_rst_n, o_valid && o_freed_count != '0, o_status == ST_OK && o_slot_id == '0 && o_slot_gen == '0)

    // A rejected request carries no generation.
    `GSA_ASSERT_IMP(a_invalid_gen, i_clk, i_rst_n, o_valid && o_status == ST_INVALID, o_slot_gen == '0 && o_freed_count == '0)

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_slot_id     (o_slot_id),
    .o_slot_gen    (o_slot_gen),
    .o_freed_count (o_freed_count)
);
`default_nettype wire

// ===== verif/slot_map_checker.sv =====
`timescale 1ns / 100ps
module slot_map_checker
    import gsa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_req_valid,
    input  wire                i_req_ready,
    input  wire [REQ_W-1:0]    i_req_type,
    input  wire [ID_W-1:0]     i_key_id,
    input  wire [GEN_W-1:0]    i_key_gen,
    input  wire                i_key_is_null,
    input  wire                i_from_start,
    input  wire                i_rsp_valid,
    input  wire                i_rsp_ready,
    input  wire [ST_W-1:0]     i_status,
    input  wire [ID_W-1:0]     i_slot_id,
    input  wire [GEN_W-1:0]    i_slot_gen,
    input  wire [CNT_W-1:0]    i_freed_count,
    output int                 o_fail_count,
    output int                 o_pending
);

    // One predicted result of the block.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  slot_id;
        logic [GEN_W-1:0] slot_gen;
        logic [CNT_W-1:0] freed_count;
    } t_answer;

    // Shadow copy of the slot table and its bookkeeping.
    logic [GEN_W-1:0]  gen_tbl [MAX_SLOTS];
    logic [COND_W-1:0] cond_tbl [MAX_SLOTS];
    logic [ID_W-1:0]   free_ids [MAX_SLOTS];
    int unsigned       free_len;
    int unsigned       fill_count;

    t_answer awaited_results [$];
    t_answer oldest;
    int      mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaited_results.size();

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_answer resolve_request(
        input logic [REQ_W-1:0] req,
        input logic [ID_W-1:0]  kid,
        input logic [GEN_W-1:0] kgen,
        input logic             knull,
        input logic             fstart
    );
        t_answer     ans;
        int unsigned id;
        int unsigned scan;
        int unsigned freed;
        logic        granted;
        logic        found;
        ans     = '0;
        granted = 1'b1;
        found   = 1'b0;
        freed   = 0;
        case (req)
            REQ_ALLOC: begin
                // Reuse the most recently freed slot, else hand out a fresh one.
                if (free_len > 0) begin
                    free_len = free_len - 1;
                    id = free_ids[free_len];
                end else if (fill_count < MAX_SLOTS) begin
                    id = fill_count;
                    fill_count = fill_count + 1;
                    gen_tbl[id] = '0;
                end else begin
                    granted = 1'b0;
                end
                if (granted) begin
                    cond_tbl[id]  = COND_LIVE;
                    ans.status    = ST_OK;
                    ans.slot_id   = ID_W'(id);
                    ans.slot_gen  = gen_tbl[id];
                end else begin
                    ans.status = ST_FULL;
                end
            end
            REQ_LOOKUP: begin
                if (knull || kid >= fill_count || gen_tbl[kid] != kgen) begin
                    ans.status = ST_INVALID;
                end else begin
                    ans.status   = ST_OK;
                    ans.slot_id  = kid;
                    ans.slot_gen = gen_tbl[kid];
                end
            end
            REQ_DESTROY: begin
                // Only live or already marked slots may be marked.
                ans.slot_id = kid;
                if (knull || kid >= fill_count ||
                    (cond_tbl[kid] != COND_LIVE && cond_tbl[kid] != COND_MARKED)) begin
                    ans.status = ST_INVALID;
                end else begin
                    cond_tbl[kid] = COND_MARKED;
                    ans.status    = ST_OK;
                    ans.slot_gen  = gen_tbl[kid];
                end
            end
            REQ_COMMIT: begin
                // Free every newly marked slot and advance its generation.
                for (scan = 0; scan < fill_count; scan++) begin
                    if (cond_tbl[scan] == COND_MARKED && free_len < MAX_SLOTS) begin
                        free_ids[free_len] = ID_W'(scan);
                        free_len           = free_len + 1;
                        cond_tbl[scan]     = COND_FREED;
                        gen_tbl[scan]      = gen_tbl[scan] + 1'b1;
                        freed              = freed + 1;
                    end
                end
                ans.status      = ST_OK;
                ans.freed_count = CNT_W'(freed);
            end
            REQ_NEXT: begin
                if (!fstart && knull) begin
                    ans.status = ST_INVALID;
                end else begin
                    scan = fstart ? 0 : kid + 1;
                    while (!found && scan < fill_count) begin
                        if (cond_tbl[scan] == COND_LIVE) begin
                            found = 1'b1;
                        end else begin
                            scan = scan + 1;
                        end
                    end
                    if (found) begin
                        ans.status   = ST_OK;
                        ans.slot_id  = ID_W'(scan);
                        ans.slot_gen = gen_tbl[scan];
                    end else begin
                        ans.status = ST_INVALID;
                    end
                end
            end
            default: begin
                ans.status = ST_INVALID;
            end
        endcase
        return ans;
    endfunction

    // Reports one field of a result that differs from its prediction.
    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < MAX_SLOTS; n++) begin
                gen_tbl[n]  = '0;
                cond_tbl[n] = COND_UNUSED;
            end
            free_len   = 0;
            fill_count = 0;
            awaited_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer with no request outstanding, actual status %0d",
                             $time, i_status);
                    mismatches = mismatches + 1;
                end else begin
                    oldest = awaited_results.pop_front();
                    flag_field("status", oldest.status, i_status);
                    flag_field("slot_id", oldest.slot_id, i_slot_id);
                    flag_field("slot_gen", oldest.slot_gen, i_slot_gen);
                    flag_field("freed_count", oldest.freed_count, i_freed_count);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(resolve_request(i_req_type, i_key_id, i_key_gen,
                                                          i_key_is_null, i_from_start));
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import gsa_pkg::*;

    localparam int CYCLE_LIMIT     = 10_000_000;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int DRAIN_CYCLES    = 32;

    // Request codes that the block leaves undefined.
    localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

    logic              clk         = 1'b1;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_ready;
    logic [REQ_W-1:0]  req_type    = REQ_ALLOC;
    logic [ID_W-1:0]   key_id      = '0;
    logic [GEN_W-1:0]  key_gen     = '0;
    logic              key_is_null = 1'b0;
    logic              from_start  = 1'b0;
    logic              rsp_valid;
    logic              rsp_ready   = 1'b1;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   slot_id;
    logic [GEN_W-1:0]  slot_gen;
    logic [CNT_W-1:0]  freed_count;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int unsigned alloc_sent = 0;

    // Idling and request mix of each random phase.
    int tx_idle_tbl [4] = '{0, 85, 0, 21};
    int rx_stall_tbl [4] = '{0, 0, 85, 21};
    int alloc_pct_tbl [4] = '{88, 88, 88, 60};

    generational_slot_allocator_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_req_type    (req_type),
        .i_key_id      (key_id),
        .i_key_gen     (key_gen),
        .i_key_is_null (key_is_null),
        .i_from_start  (from_start),
        .o_valid       (rsp_valid),
        .i_ready       (rsp_ready),
        .o_status      (status),
        .o_slot_id     (slot_id),
        .o_slot_gen    (slot_gen),
        .o_freed_count (freed_count)
    );

    slot_map_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_type    (req_type),
        .i_key_id      (key_id),
        .i_key_gen     (key_gen),
        .i_key_is_null (key_is_null),
        .i_from_start  (from_start),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_status      (status),
        .i_slot_id     (slot_id),
        .i_slot_gen    (slot_gen),
        .i_freed_count (freed_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 8 ns clock.
    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Guard against a hung block.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Picks one of the undefined request codes.
    function automatic logic [REQ_W-1:0] REG_PICK_UNDEF();
        return REQ_W'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
    endfunction

    // Presents one request, after a random idle gap, and holds it until its transfer.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] kid,
                            input logic [GEN_W-1:0] kgen, input logic knull,
                            input logic fstart);
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= req;
        key_id      <= kid;
        key_gen     <= kgen;
        key_is_null <= knull;
        from_start  <= fstart;
        if (req == REQ_ALLOC) begin
            alloc_sent = alloc_sent + 1;
        end
        do @(posedge clk); while (!req_ready);
    endtask

    // Draws one request; keys mostly point at slots that may have been handed out.
    task automatic send_random_req(input int alloc_pct);
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  kid;
        logic [GEN_W-1:0] kgen;
        int unsigned      rest;
        int unsigned      top_id;
        if ($urandom_range(99) < alloc_pct) begin
            req = REQ_ALLOC;
        end else begin
            rest = $urandom_range(99);
            if (rest < 35) begin
                req = REQ_LOOKUP;
            end else if (rest < 65) begin
                req = REQ_DESTROY;
            end else if (rest < 75) begin
                req = REQ_COMMIT;
            end else if (rest < 92) begin
                req = REQ_NEXT;
            end else begin
                req = REG_PICK_UNDEF();
            end
        end
        top_id = (alloc_sent > MAX_SLOTS) ? MAX_SLOTS - 1 : alloc_sent;
        if (top_id > 0 && $urandom_range(99) < 80) begin
            kid = ID_W'($urandom_range(top_id - 1));
        end else begin
            kid = ID_W'($urandom);
        end
        if ($urandom_range(99) < 75) begin
            kgen = GEN_W'($urandom_range(2));
        end else begin
            kgen = GEN_W'($urandom);
        end
        send_req(req, kid, kgen, $urandom_range(99) < 10, 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, fresh allocation, key checks, marking,
        // commit without re-freeing, reuse from the free stack, the walks and undefined codes.
        send_req(REQ_LOOKUP, '0, '0, 1'b0, 1'b0);
        send_req(REQ_NEXT, '0, '0, 1'b0, 1'b1);
        send_req(REQ_COMMIT, '0, '0, 1'b0, 1'b0);
        send_req(REQ_ALLOC, '0, '0, 1'b0, 1'b0);
        send_req(REQ_ALLOC, '0, '0, 1'b0, 1'b0);
        send_req(REQ_ALLOC, '0, '0, 1'b0, 1'b0);
        send_req(REQ_LOOKUP, 10'd1, 16'd0, 1'b0, 1'b0);
        send_req(REQ_LOOKUP, 10'd1, 16'd0, 1'b1, 1'b0);
        send_req(REQ_LOOKUP, 10'd1, '1, 1'b0, 1'b0);
        send_req(REQ_LOOKUP, '1, 16'd0, 1'b0, 1'b0);
        send_req(REQ_DESTROY, 10'd1, '0, 1'b0, 1'b0);
        send_req(REQ_DESTROY, 10'd1, '0, 1'b0, 1'b0);
        send_req(REQ_LOOKUP, 10'd1, 16'd0, 1'b0, 1'b0);
        send_req(REQ_DESTROY, 10'd2, '0, 1'b1, 1'b0);
        send_req(REQ_DESTROY, '1, '0, 1'b0, 1'b0);
        send_req(REQ_NEXT, 10'd0, '0, 1'b0, 1'b0);
        send_req(REQ_NEXT, 10'd0, '0, 1'b1, 1'b0);
        send_req(REQ_COMMIT, '0, '0, 1'b0, 1'b0);
        send_req(REQ_DESTROY, 10'd1, '0, 1'b0, 1'b0);
        send_req(REQ_COMMIT, '0, '0, 1'b0, 1'b0);
        send_req(REQ_LOOKUP, 10'd1, 16'd1, 1'b0, 1'b0);
        send_req(REQ_ALLOC, '0, '0, 1'b0, 1'b0);
        send_req(REQ_NEXT, 10'd2, '0, 1'b0, 1'b0);
        send_req(REQ_NEXT, '1, '1, 1'b1, 1'b1);
        send_req(REQ_UNDEF_LO, '0, '0, 1'b0, 1'b0);
        send_req(REQ_UNDEF_HI, '0, '0, 1'b0, 1'b0);

        // Random part: the table fills over the first phases and runs full in the last.
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_idle_tbl[ph];
            rx_stall_pct = rx_stall_tbl[ph];
            repeat (ITEMS_PER_PHASE) send_random_req(alloc_pct_tbl[ph]);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        rx_stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
